[sv/ofmrq_pkg.sv]
// ----------------------------------------------------------------------------
// ofmrq_pkg: shared types and constants for the output row requantizer
// Lane count, field widths, clamp limits, register indexes and control structs.
// ----------------------------------------------------------------------------
package ofmrq_pkg;

    localparam int LANES     = 8;
    localparam int HALF      = LANES / 2;
    localparam int SUM_W     = 32;
    localparam int OUT_W     = 16;
    localparam int SHIFT_W   = 5;
    localparam int CH_W      = 12;
    localparam int NCH_W     = 13;
    localparam int STEP_W    = 16;
    localparam int ROW_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int ADDR_BITS = 16;

    localparam int ACT_LO_FINAL = -128;
    localparam int ACT_HI       = 127;
    localparam int WORD_CAP     = 32767;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REQUANT_SHIFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_TWO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_LAYER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_CHANNELS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP       = 3'd4;

    // reset values
    localparam logic [SHIFT_W-1:0] RST_REQUANT_SHIFT  = 5'd8;
    localparam logic [NCH_W-1:0]   RST_INPUT_CHANNELS = 13'd1;
    localparam logic [STEP_W-1:0]  RST_ROW_STEP       = 16'd1;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [OUT_W-1:0] t_word;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic               last;
        logic               final_layer;
    } t_lane_ctrl;

    typedef struct packed {
        logic stride_two;
        logic column_odd;
    } t_row_ctrl;

endpackage

[sv/ofmrq_lane.sv]
// ----------------------------------------------------------------------------
// ofmrq_lane: requantize one accumulator sum
// Round half up, arithmetic shift, optional activation clamp, 16-bit cap.
// ----------------------------------------------------------------------------
module ofmrq_lane (
    input  ofmrq_pkg::t_sum       i_sum,
    input  ofmrq_pkg::t_lane_ctrl i_ctrl,
    output ofmrq_pkg::t_word      o_word
);

    localparam int VW = ofmrq_pkg::SUM_W + 1;

    localparam logic signed [VW-1:0] ONE      = VW'(1);
    localparam logic signed [VW-1:0] ZERO     = '0;
    localparam logic signed [VW-1:0] LO_FINAL = VW'(ofmrq_pkg::ACT_LO_FINAL);
    localparam logic signed [VW-1:0] HI_ACT   = VW'(ofmrq_pkg::ACT_HI);
    localparam logic signed [VW-1:0] HI_CAP   = VW'(ofmrq_pkg::WORD_CAP);

    logic signed [VW-1:0] w_round;
    logic signed [VW-1:0] w_shift;
    logic signed [VW-1:0] w_lo;
    logic signed [VW-1:0] w_val;

    // one guard bit keeps sum + half from wrapping
    always_comb begin
        w_round = {i_sum[ofmrq_pkg::SUM_W-1], i_sum};
        if (i_ctrl.shift != '0) begin
            w_round = w_round + (ONE << (i_ctrl.shift - 1'b1));
        end
        w_shift = w_round >>> i_ctrl.shift;
        w_lo    = i_ctrl.final_layer ? LO_FINAL : ZERO;
        w_val   = w_shift;
        if (i_ctrl.last) begin
            if (w_val < w_lo) begin
                w_val = w_lo;
            end
            if (w_val > HI_ACT) begin
                w_val = HI_ACT;
            end
        end
        if (w_val > HI_CAP) begin
            w_val = HI_CAP;
        end
    end

    // below the cap only the low bits are kept, large negatives wrap
    assign o_word = w_val[ofmrq_pkg::OUT_W-1:0];

endmodule

[sv/ofmrq_out_stage.sv]
// ----------------------------------------------------------------------------
// ofmrq_out_stage: lane requantizers, slot packing and result register
// Packs even lanes into one half of the row in stride-two mode.
// ----------------------------------------------------------------------------
module ofmrq_out_stage (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  ofmrq_pkg::t_sum                      i_sum [ofmrq_pkg::LANES],
    input  ofmrq_pkg::t_lane_ctrl                i_lane_ctrl,
    input  ofmrq_pkg::t_row_ctrl                 i_row_ctrl,
    input  logic [ofmrq_pkg::ROW_W-1:0]          i_row_address,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output ofmrq_pkg::t_word                     o_word [ofmrq_pkg::LANES],
    output logic [ofmrq_pkg::LANES-1:0]          o_write_mask,
    output logic [ofmrq_pkg::ROW_W-1:0]          o_row_address
);

    localparam int LANES = ofmrq_pkg::LANES;
    localparam int HALF  = ofmrq_pkg::HALF;

    ofmrq_pkg::t_word            w_lane [LANES];
    ofmrq_pkg::t_word            w_src  [LANES];
    logic [LANES-1:0]            w_sel;

    logic                        r_valid;
    ofmrq_pkg::t_word            r_word [LANES];
    logic [LANES-1:0]            r_mask;
    logic [ofmrq_pkg::ROW_W-1:0] r_row_address;

    logic                        w_load;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        ofmrq_lane u_lane (
            .i_sum  (i_sum[l]),
            .i_ctrl (i_lane_ctrl),
            .o_word (w_lane[l])
        );
    end

    for (genvar j = 0; j < LANES; j++) begin : g_slot
        if (j < HALF) begin : g_lo
            assign w_sel[j] = i_row_ctrl.stride_two ? !i_row_ctrl.column_odd : 1'b1;
            assign w_src[j] = i_row_ctrl.stride_two ? w_lane[2*j] : w_lane[j];
        end else if (j < 2*HALF) begin : g_hi
            assign w_sel[j] = i_row_ctrl.stride_two ? i_row_ctrl.column_odd : 1'b1;
            assign w_src[j] = i_row_ctrl.stride_two ? w_lane[2*(j-HALF)] : w_lane[j];
        end else begin : g_odd
            // odd lane count: the top slot has no even-lane source
            assign w_sel[j] = !i_row_ctrl.stride_two;
            assign w_src[j] = w_lane[j];
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int j = 0; j < LANES; j++) begin
                r_word[j] <= w_sel[j] ? w_src[j] : '0;
            end
            r_mask        <= w_sel;
            r_row_address <= i_row_address;
        end
    end

    assign o_valid       = r_valid;
    assign o_word        = r_word;
    assign o_write_mask  = r_mask;
    assign o_row_address = r_row_address;

endmodule

[sv/ofm_row_requantize_store_core.sv]
// ----------------------------------------------------------------------------
// ofm_row_requantize_store_core: output feature-map row requantizer
// Rounds, shifts, activates and saturates a row of accumulator sums and tags
// it with a write mask and the next feature-map row address.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | contents
//  ---------+-----------+-------------------------+-----------------------------
//  input    | in        | i_in_valid / o_in_ready | sums, column parity, channel
//  output   | out       | o_out_valid/i_out_ready | words, write mask, row addr
//  config   | in        | i_cfg_we                | index i_cfg_addr, i_cfg_wdata
//
//  One word per cycle sustained while the output is not stalled; words pass
//  through the input register, the lane requantizers and the result register.
//  Synchronous active-low reset clears valids and row pointer, presets config.
//  A stalled result only holds its own register; the input register still takes
//  a word, and input ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module ofm_row_requantize_store_core #(
    parameter int ADDR_BITS = ofmrq_pkg::ADDR_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ofmrq_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [ofmrq_pkg::CFG_DAT_W-1:0]      i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [ofmrq_pkg::SUM_W-1:0]   i_sum_0,
    input  logic signed [ofmrq_pkg::SUM_W-1:0]   i_sum_1,
    input  logic signed [ofmrq_pkg::SUM_W-1:0]   i_sum_2,
    input  logic signed [ofmrq_pkg::SUM_W-1:0]   i_sum_3,
    input  logic signed [ofmrq_pkg::SUM_W-1:0]   i_sum_4,
    input  logic signed [ofmrq_pkg::SUM_W-1:0]   i_sum_5,
    input  logic signed [ofmrq_pkg::SUM_W-1:0]   i_sum_6,
    input  logic signed [ofmrq_pkg::SUM_W-1:0]   i_sum_7,
    input  logic                                 i_column_odd,
    input  logic [ofmrq_pkg::CH_W-1:0]           i_channel_index,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [ofmrq_pkg::OUT_W-1:0]   o_out_0,
    output logic signed [ofmrq_pkg::OUT_W-1:0]   o_out_1,
    output logic signed [ofmrq_pkg::OUT_W-1:0]   o_out_2,
    output logic signed [ofmrq_pkg::OUT_W-1:0]   o_out_3,
    output logic signed [ofmrq_pkg::OUT_W-1:0]   o_out_4,
    output logic signed [ofmrq_pkg::OUT_W-1:0]   o_out_5,
    output logic signed [ofmrq_pkg::OUT_W-1:0]   o_out_6,
    output logic signed [ofmrq_pkg::OUT_W-1:0]   o_out_7,
    output logic [ofmrq_pkg::LANES-1:0]          o_write_mask,
    output logic [ofmrq_pkg::ROW_W-1:0]          o_row_address
);

    localparam int LANES = ofmrq_pkg::LANES;
    localparam int HALF  = ofmrq_pkg::HALF;

    // config registers
    logic [ofmrq_pkg::SHIFT_W-1:0] r_requant_shift;
    logic                          r_stride_two;
    logic                          r_final_layer;
    logic [ofmrq_pkg::NCH_W-1:0]   r_input_channels;
    logic [ofmrq_pkg::STEP_W-1:0]  r_row_step;

    logic [ADDR_BITS-1:0]          r_row_ptr;

    // input register
    logic                          r_s1_valid;
    ofmrq_pkg::t_sum               r_s1_sum [LANES];
    logic                          r_s1_odd;
    logic                          r_s1_last;
    logic [ofmrq_pkg::ROW_W-1:0]   r_s1_addr;

    ofmrq_pkg::t_sum               w_in_sum [LANES];
    ofmrq_pkg::t_word              w_out_word [LANES];
    ofmrq_pkg::t_lane_ctrl         w_lane_ctrl;
    ofmrq_pkg::t_row_ctrl          w_row_ctrl;
    logic                          w_os_ready;
    logic                          w_in_acc;
    logic                          w_s1_adv;
    logic                          w_last;

    assign w_in_sum[0] = i_sum_0;
    assign w_in_sum[1] = i_sum_1;
    assign w_in_sum[2] = i_sum_2;
    assign w_in_sum[3] = i_sum_3;
    assign w_in_sum[4] = i_sum_4;
    assign w_in_sum[5] = i_sum_5;
    assign w_in_sum[6] = i_sum_6;
    assign w_in_sum[7] = i_sum_7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_requant_shift  <= ofmrq_pkg::RST_REQUANT_SHIFT;
            r_stride_two     <= 1'b0;
            r_final_layer    <= 1'b0;
            r_input_channels <= ofmrq_pkg::RST_INPUT_CHANNELS;
            r_row_step       <= ofmrq_pkg::RST_ROW_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ofmrq_pkg::REG_REQUANT_SHIFT: begin
                    r_requant_shift <= i_cfg_wdata[ofmrq_pkg::SHIFT_W-1:0];
                end
                ofmrq_pkg::REG_STRIDE_TWO: begin
                    r_stride_two <= i_cfg_wdata[0];
                end
                ofmrq_pkg::REG_FINAL_LAYER: begin
                    r_final_layer <= i_cfg_wdata[0];
                end
                ofmrq_pkg::REG_INPUT_CHANNELS: begin
                    r_input_channels <= i_cfg_wdata[ofmrq_pkg::NCH_W-1:0];
                end
                ofmrq_pkg::REG_ROW_STEP: begin
                    r_row_step <= i_cfg_wdata[ofmrq_pkg::STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a zero channel count never matches
    assign w_last = (r_input_channels != '0) &&
                    ({1'b0, i_channel_index} == (r_input_channels - 1'b1));

    assign w_s1_adv   = r_s1_valid && w_os_ready;
    assign o_in_ready = !r_s1_valid || w_os_ready;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_row_ptr  <= '0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
                r_row_ptr  <= r_row_ptr + ADDR_BITS'(r_row_step);
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_sum  <= w_in_sum;
            r_s1_odd  <= i_column_odd;
            r_s1_last <= w_last;
            r_s1_addr <= ofmrq_pkg::ROW_W'(r_row_ptr);
        end
    end

    assign w_lane_ctrl.shift       = r_requant_shift;
    assign w_lane_ctrl.last        = r_s1_last;
    assign w_lane_ctrl.final_layer = r_final_layer;
    assign w_row_ctrl.stride_two   = r_stride_two;
    assign w_row_ctrl.column_odd   = r_s1_odd;

    ofmrq_out_stage u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_s1_valid),
        .o_ready       (w_os_ready),
        .i_sum         (r_s1_sum),
        .i_lane_ctrl   (w_lane_ctrl),
        .i_row_ctrl    (w_row_ctrl),
        .i_row_address (r_s1_addr),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_word        (w_out_word),
        .o_write_mask  (o_write_mask),
        .o_row_address (o_row_address)
    );

    assign o_out_0 = w_out_word[0];
    assign o_out_1 = w_out_word[1];
    assign o_out_2 = w_out_word[2];
    assign o_out_3 = w_out_word[3];
    assign o_out_4 = w_out_word[4];
    assign o_out_5 = w_out_word[5];
    assign o_out_6 = w_out_word[6];
    assign o_out_7 = w_out_word[7];

    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_row_ptr == $past(r_row_ptr) + ADDR_BITS'($past(r_row_step)))
        else $error("row pointer did not advance by row_step");

    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_row_ptr))
        else $error("row pointer moved without an input word");

    a_full_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_stride_two |-> o_write_mask == '1)
        else $error("full row without full write mask");

    a_half_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_stride_two |-> $countones(o_write_mask) == HALF)
        else $error("stride-two row mask not half a row");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && r_s1_valid |-> w_s1_adv)
        else $error("input register overwritten while full");

endmodule
